@@ rtl/plci_pkg.sv @@
package plci_pkg;

  localparam int MAX_POINTS_DEF = 8;
  localparam int QUEUE_DEPTH    = 2;

  localparam int POS_W     = 32;
  localparam int COLOR_W   = 32;
  localparam int INDEX_W   = 3;
  localparam int COUNT_W   = 4;
  localparam int FRAC_BITS = 16;
  localparam int CHAN_BITS = 8;
  localparam int CHANNELS  = COLOR_W / CHAN_BITS;

  // Difference of two positions, its magnitude scaled by the fraction, the quotient
  localparam int DIFF_W  = POS_W + 1;
  localparam int NUM_W   = DIFF_W + FRAC_BITS;
  localparam int RATIO_W = NUM_W + 1;

  localparam logic [COUNT_W-1:0]   COUNT_RESET = 4'd2;
  localparam logic [CHAN_BITS-1:0] CHAN_MAX    = 8'd255;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_EVAL  = 1'b1;

  // Classified word handed from the front to the back
  typedef struct packed {
    logic                  is_eval;
    logic [INDEX_W-1:0]    index;
    logic [POS_W-1:0]      key;    // breakpoint position or sample value
    logic [COLOR_W-1:0]    color;
  } item_t;

endpackage

@@ rtl/plci_ram.sv @@
module plci_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/plci_front.sv @@
module plci_front
  import plci_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               func,
  input  logic [INDEX_W-1:0] entry_index,
  input  logic [POS_W-1:0]   entry_position,
  input  logic [COLOR_W-1:0] entry_color,
  input  logic [POS_W-1:0]   sample_value,
  output logic               q_valid,
  output item_t              q_item,
  input  logic               q_pop
);

  localparam int PW = $clog2(QUEUE_DEPTH);

  item_t         slots [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [PW:0]   fill;
  logic          push;
  logic          pop;
  item_t         in_item;

  // Classify: evaluate words carry the sample, write words the position
  always_comb begin
    in_item.is_eval = (func == FUNC_EVAL);
    in_item.index   = entry_index;
    in_item.key     = (func == FUNC_EVAL) ? sample_value : entry_position;
    in_item.color   = entry_color;
  end

  assign busy    = (fill == (PW + 1)'(QUEUE_DEPTH));
  assign push    = start && !busy;
  assign q_valid = (fill != '0);
  assign pop     = q_pop && q_valid;
  assign q_item  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

@@ rtl/plci_back.sv @@
module plci_back
  import plci_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [COUNT_W-1:0] point_count,
  input  logic               q_valid,
  input  item_t              q_item,
  output logic               q_pop,
  output logic               done,
  output logic [COLOR_W-1:0] color_out
);

  localparam int AW  = $clog2(MAX_POINTS);
  localparam int NW  = $clog2(MAX_POINTS + 1);
  localparam int DCW = $clog2(NUM_W);
  localparam int PROD_W = CHAN_BITS + 1 + RATIO_W;
  localparam int SUM_W  = PROD_W + 2;

  typedef enum logic [10:0] {
    ST_IDLE = 11'b00000000001,
    ST_SCAN = 11'b00000000010,
    ST_TEST = 11'b00000000100,
    ST_RD1  = 11'b00000001000,
    ST_LD1  = 11'b00000010000,
    ST_LD0  = 11'b00000100000,
    ST_CHK  = 11'b00001000000,
    ST_DIV  = 11'b00010000000,
    ST_SIGN = 11'b00100000000,
    ST_MUL  = 11'b01000000000,
    ST_ACC  = 11'b10000000000
  } state_t;

  state_t state;

  logic [NW-1:0]  n_use;
  logic [NW-1:0]  n_m1;
  logic [AW-1:0]  last_idx;
  logic [AW-1:0]  idx;
  logic [AW-1:0]  raddr;
  logic [31:0]    slot_wide;
  logic           ram_we;
  logic [POS_W-1:0]   pos_rdata;
  logic [COLOR_W-1:0] col_rdata;

  logic signed [POS_W-1:0] v;
  logic signed [POS_W-1:0] p0;
  logic signed [POS_W-1:0] p1;
  logic [COLOR_W-1:0] c0;
  logic [COLOR_W-1:0] c1;

  logic signed [DIFF_W-1:0] d;
  logic signed [DIFF_W-1:0] den;
  logic [DIFF_W-1:0] d_mag;
  logic [DIFF_W-1:0] den_mag_c;

  logic              neg;
  logic [DIFF_W-1:0] den_mag;
  logic [DIFF_W-1:0] rem;
  logic [NUM_W-1:0]  work;
  logic [DCW-1:0]    div_cnt;
  logic [DIFF_W:0]   rem_sh;
  logic              q_bit;

  logic signed [RATIO_W-1:0] ratio;
  logic [RATIO_W-1:0]        q_ext;
  logic [1:0]                ch;
  logic [CHAN_BITS-1:0]      ch_a;
  logic [CHAN_BITS-1:0]      ch_b;
  logic signed [CHAN_BITS:0] ch_diff;
  logic signed [PROD_W-1:0]  prod;
  logic [SUM_W-1:0]          sum;
  logic [SUM_W-1:0]          sum_rnd;
  logic [CHAN_BITS-1:0]      ch_res;
  logic [COLOR_W-1:0]        res;

  // Clamp the breakpoint count into 2 .. MAX_POINTS
  always_comb begin
    if (int'(point_count) < 2) begin
      n_use = NW'(2);
    end else if (int'(point_count) > MAX_POINTS) begin
      n_use = NW'(MAX_POINTS);
    end else begin
      n_use = NW'(point_count);
    end
    n_m1     = n_use - NW'(1);
    last_idx = n_m1[AW-1:0];
  end

  assign q_pop     = q_valid && (state == ST_IDLE);
  assign slot_wide = 32'(q_item.index);
  assign ram_we    = q_pop && !q_item.is_eval && (slot_wide < 32'(MAX_POINTS));
  assign raddr     = (state == ST_LD1) ? idx - 1'b1 : idx;

  plci_ram #(.WIDTH(POS_W), .DEPTH(MAX_POINTS)) u_pos_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot_wide[AW-1:0]),
    .wdata (q_item.key),
    .raddr (raddr),
    .rdata (pos_rdata)
  );

  plci_ram #(.WIDTH(COLOR_W), .DEPTH(MAX_POINTS)) u_col_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot_wide[AW-1:0]),
    .wdata (q_item.color),
    .raddr (raddr),
    .rdata (col_rdata)
  );

  // Segment deltas and their magnitudes for the divider
  always_comb begin
    d         = DIFF_W'(v) - DIFF_W'(p0);
    den       = DIFF_W'(p1) - DIFF_W'(p0);
    d_mag     = d[DIFF_W-1] ? (~d + 1'b1) : d;
    den_mag_c = den[DIFF_W-1] ? (~den + 1'b1) : den;
  end

  // One restoring step per cycle
  always_comb begin
    rem_sh = {rem, work[NUM_W-1]};
    q_bit  = (rem_sh >= {1'b0, den_mag});
  end

  // One channel per pass: product, then offset, round and saturate
  always_comb begin
    ch_a    = CHAN_BITS'(c0 >> {ch, 3'b000});
    ch_b    = CHAN_BITS'(c1 >> {ch, 3'b000});
    ch_diff = $signed({1'b0, ch_b}) - $signed({1'b0, ch_a});
    q_ext   = {1'b0, work};
    sum     = SUM_W'({ch_a, {FRAC_BITS{1'b0}}}) + SUM_W'(prod);
    sum_rnd = sum + SUM_W'(1 << (FRAC_BITS - 1));
    if (sum[SUM_W-1]) begin
      ch_res = '0;
    end else if (|sum_rnd[SUM_W-1:FRAC_BITS+CHAN_BITS]) begin
      ch_res = CHAN_MAX;
    end else begin
      ch_res = sum_rnd[FRAC_BITS +: CHAN_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (q_pop && q_item.is_eval) begin
            v     <= q_item.key;
            idx   <= AW'(1);
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          state <= (idx == last_idx) ? ST_RD1 : ST_TEST;
        end
        ST_TEST: begin
          if ($signed(pos_rdata) >= v) begin
            state <= ST_RD1;
          end else begin
            idx   <= idx + 1'b1;
            state <= ST_SCAN;
          end
        end
        ST_RD1: begin
          state <= ST_LD1;
        end
        ST_LD1: begin
          p1    <= pos_rdata;
          c1    <= col_rdata;
          state <= ST_LD0;
        end
        ST_LD0: begin
          p0    <= pos_rdata;
          c0    <= col_rdata;
          state <= ST_CHK;
        end
        ST_CHK: begin
          if (c0 == c1) begin
            color_out <= c0;
            done      <= 1'b1;
            state     <= ST_IDLE;
          end else if (p0 == p1) begin
            color_out <= (v <= p0) ? c0 : c1;
            done      <= 1'b1;
            state     <= ST_IDLE;
          end else begin
            neg     <= d[DIFF_W-1] ^ den[DIFF_W-1];
            den_mag <= den_mag_c;
            rem     <= '0;
            work    <= {d_mag, {FRAC_BITS{1'b0}}};
            div_cnt <= '0;
            state   <= ST_DIV;
          end
        end
        ST_DIV: begin
          rem     <= q_bit ? DIFF_W'(rem_sh - {1'b0, den_mag}) : DIFF_W'(rem_sh);
          work    <= {work[NUM_W-2:0], q_bit};
          div_cnt <= div_cnt + 1'b1;
          if (div_cnt == DCW'(NUM_W - 1)) begin
            state <= ST_SIGN;
          end
        end
        ST_SIGN: begin
          ratio <= neg ? $signed(~q_ext + 1'b1) : $signed(q_ext);
          ch    <= '0;
          state <= ST_MUL;
        end
        ST_MUL: begin
          prod  <= ch_diff * ratio;
          state <= ST_ACC;
        end
        ST_ACC: begin
          res[{ch, 3'b000} +: CHAN_BITS] <= ch_res;
          ch <= ch + 1'b1;
          if (ch == 2'(CHANNELS - 1)) begin
            color_out <= {ch_res, res[COLOR_W-CHAN_BITS-1:0]};
            done      <= 1'b1;
            state     <= ST_IDLE;
          end else begin
            state <= ST_MUL;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/piecewise_linear_color_interpolator_core.sv @@
// Channel   Ports                                                          Handshake
// ------    -------------------------------------------------------------  --------------
// item      func entry_index entry_position entry_color sample_value        start && !busy
// result    color_out                                                      done, one cycle
// config    cfg_data (point_count)                                         cfg_write
//
// A write word updates the table in the cycle the back end pops it. An evaluate word scans
// the table for the first breakpoint at or above the sample, stopping at the last breakpoint,
// then runs the divider and four channel passes before done.
// Equal colors or equal positions finish after the check. A taken word is queued and popped
// once the back end is idle. Reset (rst, synchronous) clears the queue and the
// sequencer and sets point_count to 2, not the table; busy rises only on a full two-word queue.
module piecewise_linear_color_interpolator_core
  import plci_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               func,
  input  logic [INDEX_W-1:0] entry_index,
  input  logic [POS_W-1:0]   entry_position,
  input  logic [COLOR_W-1:0] entry_color,
  input  logic [POS_W-1:0]   sample_value,
  output logic               done,
  output logic [COLOR_W-1:0] color_out,
  input  logic               cfg_write,
  input  logic [COUNT_W-1:0] cfg_data
);

  logic [COUNT_W-1:0] point_count;
  logic               q_valid;
  logic               q_pop;
  item_t              q_item;

  // Hold the breakpoint count; the user is to write it only while the block is idle (not enforced here)
  always_ff @(posedge clk) begin
    if (rst) begin
      point_count <= COUNT_RESET;
    end else if (cfg_write) begin
      point_count <= cfg_data;
    end
  end

  // Front: accept and classify each word, queue it for the back end
  plci_front u_front (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .func           (func),
    .entry_index    (entry_index),
    .entry_position (entry_position),
    .entry_color    (entry_color),
    .sample_value   (sample_value),
    .q_valid        (q_valid),
    .q_item         (q_item),
    .q_pop          (q_pop)
  );

  // Back: update the table, or search, divide and blend, in queue order
  plci_back #(.MAX_POINTS(MAX_POINTS)) u_back (
    .clk         (clk),
    .rst         (rst),
    .point_count (point_count),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .q_pop       (q_pop),
    .done        (done),
    .color_out   (color_out)
  );

endmodule
